// File: hdl/spdn_pkg.sv
// ----------------------------------------------------------------------------
// spdn_pkg
// shared types and constants of the spectrum peak decay normalizer
// ----------------------------------------------------------------------------
package spdn_pkg;

  localparam int BANDS_DEFAULT   = 32;
  localparam int ONE_Q12         = 4096;
  localparam int HOLD_STEP_RESET = 20;
  localparam int DIV_BITS        = 12;
  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES      = DIV_BITS / STEPS_PER_STAGE;

  // floor(avg / 120) and floor(avg / 500) by reciprocal, exact over 15 bits
  localparam logic [15:0] TRIG_MUL   = 16'd34953;
  localparam int          TRIG_SHIFT = 22;
  localparam logic [15:0] PEAK_MUL   = 16'd33555;
  localparam int          PEAK_SHIFT = 24;

  // register indexes
  localparam logic [1:0] REG_HOLD_STEP   = 2'd0;
  localparam logic [1:0] REG_BEAM_ENABLE = 2'd1;

  typedef struct packed {
    logic [4:0]         band;
    logic signed [15:0] level;
    logic [14:0]        band_average;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  out_band;
    logic [12:0] cube_value;
    logic [12:0] beam_value;
    logic        beam_valid;
  } out_item_t;

  // front stage: input item plus decay amounts
  typedef struct packed {
    in_item_t   item;
    logic [8:0] trig_dec;
    logic [6:0] peak_dec;
  } front_t;

  // one normalization in flight
  typedef struct packed {
    logic        special;
    logic        one;
    logic [15:0] rem;
    logic [14:0] den;
    logic [11:0] quo;
  } lane_t;

  typedef struct packed {
    logic [4:0] band;
    logic       beam_valid;
    lane_t      cube;
    lane_t      beam;
  } pipe_t;

endpackage

// File: hdl/spdn_front.sv
// ----------------------------------------------------------------------------
// spdn_front
// input register with decay amounts taken from the band average
// ----------------------------------------------------------------------------
module spdn_front (
  input  logic              clk,
  input  logic              en,
  input  spdn_pkg::in_item_t item,
  output spdn_pkg::front_t   front
);

  logic [30:0] trig_prod;
  logic [30:0] peak_prod;

  assign trig_prod = 31'(item.band_average) * 31'(spdn_pkg::TRIG_MUL);
  assign peak_prod = 31'(item.band_average) * 31'(spdn_pkg::PEAK_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      front.item     <= item;
      front.trig_dec <= 9'(trig_prod >> spdn_pkg::TRIG_SHIFT);
      front.peak_dec <= 7'(peak_prod >> spdn_pkg::PEAK_SHIFT);
    end
  end

endmodule

// File: hdl/spdn_store.sv
// ----------------------------------------------------------------------------
// spdn_store
// per-band peak, hold and trigger stores, read-modify-write in one stage
// ----------------------------------------------------------------------------
module spdn_store #(
  parameter int BANDS = spdn_pkg::BANDS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             upd,
  input  spdn_pkg::front_t front,
  input  logic [11:0]      hold_step,
  input  logic             beam_enable,
  output spdn_pkg::pipe_t  pipe
);

  localparam int IW = (BANDS > 1) ? $clog2(BANDS) : 1;

  logic signed [15:0] peak_q [BANDS];
  logic signed [15:0] hold_q [BANDS];
  logic signed [15:0] trig_q [BANDS];

  logic [IW-1:0]      idx;
  logic               in_range;
  logic signed [15:0] lvl, peak_rd, hold_rd, trig_rd;
  logic signed [15:0] peak_up, hold_up, trig_up;
  logic               reload;
  logic signed [16:0] cube_num;
  logic signed [15:0] peak_next, hold_next, trig_next;
  spdn_pkg::pipe_t    pipe_next;

  function automatic logic signed [15:0] sat_sub(logic signed [15:0] v, logic [11:0] d);
    logic signed [16:0] r;
    r = 17'(v) - $signed({5'b0, d});
    return (r < -17'sd32768) ? -16'sd32768 : r[15:0];
  endfunction

  function automatic spdn_pkg::lane_t classify(logic signed [16:0] num,
                                               logic signed [15:0] p, logic force0);
    spdn_pkg::lane_t l;
    l.special = 1'b1;
    l.one     = 1'b0;
    l.rem     = num[15:0];
    l.den     = p[14:0];
    l.quo     = '0;
    if (force0) begin
      l.one = 1'b0;
    end else if (p <= 16'sd0) begin
      l.one = (num >= 17'(p));
    end else if (num <= 17'sd0) begin
      l.one = 1'b0;
    end else if (num >= 17'(p)) begin
      l.one = 1'b1;
    end else begin
      l.special = 1'b0;
    end
    return l;
  endfunction

  assign idx      = IW'(front.item.band);
  assign in_range = (32'(front.item.band) < BANDS);
  assign lvl      = front.item.level;
  assign peak_rd  = peak_q[idx];
  assign hold_rd  = hold_q[idx];
  assign trig_rd  = trig_q[idx];

  always_comb begin
    peak_up  = (lvl > peak_rd) ? lvl : peak_rd;
    hold_up  = (lvl > hold_rd) ? lvl : hold_rd;
    reload   = (lvl > 16'sd0) && (trig_rd < 16'sd0);
    trig_up  = reload ? lvl : trig_rd;
    cube_num = 17'(hold_up) - $signed({2'b0, front.item.band_average});

    trig_next = (trig_up >= 16'sd0) ? sat_sub(trig_up, {3'b0, front.trig_dec}) : trig_up;
    hold_next = (hold_up >= 16'sd0) ? sat_sub(hold_up, hold_step) : hold_up;
    peak_next = (peak_up >= 16'sd0) ? sat_sub(peak_up, {5'b0, front.peak_dec}) : peak_up;

    pipe_next.band       = front.item.band;
    pipe_next.beam_valid = in_range && reload && beam_enable;
    pipe_next.cube       = classify(cube_num, peak_up, !in_range);
    pipe_next.beam       = classify(17'(lvl), peak_up, !pipe_next.beam_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BANDS; i++) begin
        peak_q[i] <= 16'(spdn_pkg::ONE_Q12);
        hold_q[i] <= '0;
        trig_q[i] <= '0;
      end
    end else if (upd && in_range) begin
      peak_q[idx] <= peak_next;
      hold_q[idx] <= hold_next;
      trig_q[idx] <= trig_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe <= pipe_next;
    end
  end

endmodule

// File: hdl/spdn_div_stage.sv
// ----------------------------------------------------------------------------
// spdn_div_stage
// one stage of the restoring divider, a few quotient bits per lane
// ----------------------------------------------------------------------------
module spdn_div_stage (
  input  logic            clk,
  input  logic            en,
  input  spdn_pkg::pipe_t pipe_in,
  output spdn_pkg::pipe_t pipe_out
);

  spdn_pkg::pipe_t pipe_next;

  function automatic spdn_pkg::lane_t steps(spdn_pkg::lane_t l);
    spdn_pkg::lane_t o;
    logic [16:0]     r2;
    o = l;
    for (int s = 0; s < spdn_pkg::STEPS_PER_STAGE; s++) begin
      r2 = {o.rem, 1'b0};
      if (r2 >= {2'b0, o.den}) begin
        r2    = r2 - {2'b0, o.den};
        o.quo = {o.quo[10:0], 1'b1};
      end else begin
        o.quo = {o.quo[10:0], 1'b0};
      end
      o.rem = r2[15:0];
    end
    return o;
  endfunction

  always_comb begin
    pipe_next      = pipe_in;
    pipe_next.cube = steps(pipe_in.cube);
    pipe_next.beam = steps(pipe_in.beam);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_out <= pipe_next;
    end
  end

endmodule

// File: hdl/spectrum_peak_decay_normalizer.sv
// ----------------------------------------------------------------------------
// spectrum_peak_decay_normalizer
// per-band peak hold level meter with decay, normalized cube and beam values
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_item  (band, level, average)
//   out     | output    | out_valid/out_stall| out_item (band, cube, beam)
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one item per cycle while out_stall is low
// stages: input + decay amounts, store update, four divider stages of 3 bits
// synchronous reset loads the stores (peak 1.0, hold and trigger 0) at once
// stall holds only the stages that are full, bubbles still close up
// ----------------------------------------------------------------------------
module spectrum_peak_decay_normalizer #(
  parameter int BANDS = spdn_pkg::BANDS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  spdn_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output spdn_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [11:0]         cfg_data
);

  localparam int NST = 2 + spdn_pkg::DIV_STAGES;

  // valid bit per stage and the advance chain
  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  // config registers
  logic [11:0] hold_step;
  logic        beam_enable;

  spdn_pkg::front_t front;
  spdn_pkg::pipe_t  pipe [spdn_pkg::DIV_STAGES+1];
  spdn_pkg::pipe_t  last;

  assign rdy[NST] = !out_stall;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end

  assign in_stall  = !rdy[0];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v           <= '0;
      hold_step   <= 12'(spdn_pkg::HOLD_STEP_RESET);
      beam_enable <= 1'b1;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          spdn_pkg::REG_HOLD_STEP:   hold_step   <= cfg_data;
          spdn_pkg::REG_BEAM_ENABLE: beam_enable <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // decay amounts from the average
  spdn_front u_front (
    .clk   (clk),
    .en    (rdy[0]),
    .item  (in_item),
    .front (front)
  );

  // stores change only when a real item moves into the next stage
  spdn_store #(.BANDS(BANDS)) u_store (
    .clk         (clk),
    .rst         (rst),
    .en          (rdy[1]),
    .upd         (v[0] && rdy[1]),
    .front       (front),
    .hold_step   (hold_step),
    .beam_enable (beam_enable),
    .pipe        (pipe[0])
  );

  for (genvar d = 0; d < spdn_pkg::DIV_STAGES; d++) begin : g_div
    spdn_div_stage u_div (
      .clk      (clk),
      .en       (rdy[d+2]),
      .pipe_in  (pipe[d]),
      .pipe_out (pipe[d+1])
    );
  end

  assign last      = pipe[spdn_pkg::DIV_STAGES];
  assign out_valid = v[NST-1];

  always_comb begin
    out_item.out_band   = last.band;
    out_item.beam_valid = last.beam_valid;
    out_item.cube_value = last.cube.special ? (last.cube.one ? 13'(spdn_pkg::ONE_Q12) : '0)
                                            : {1'b0, last.cube.quo};
    out_item.beam_value = last.beam.special ? (last.beam.one ? 13'(spdn_pkg::ONE_Q12) : '0)
                                            : {1'b0, last.beam.quo};
  end

  // no beam without its valid flag
  a_beam_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.beam_valid |-> out_item.beam_value == 13'd0)
    else $error("beam value without beam_valid");

  // normalized values never exceed 1.0
  a_cube_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.cube_value <= 13'(spdn_pkg::ONE_Q12)
               && out_item.beam_value <= 13'(spdn_pkg::ONE_Q12))
    else $error("normalized value above one");

  // bands beyond the store give an empty result
  a_band_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (32'(out_item.out_band) >= BANDS)
      |-> out_item.cube_value == 13'd0 && !out_item.beam_valid)
    else $error("result for band out of range");

  // an item held at the output is not lost while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

endmodule
